### design/vrt_pkg.sv
package vrt_pkg;

    localparam int COORD_W        = 32;
    localparam int DIST_W         = 32;
    localparam int DIST_FRAC_BITS = 16;
    localparam int DIR_FRAC_BITS  = 14;
    localparam int DIR_W          = DIR_FRAC_BITS + 2;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_ANSWER = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic signed [COORD_W-1:0]  origin_z;
        logic signed [DIR_W-1:0]    dir_x;
        logic signed [DIR_W-1:0]    dir_y;
        logic signed [DIR_W-1:0]    dir_z;
        logic                       occupied;
    } vrt_in_t;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [COORD_W-1:0]  voxel_x;
        logic signed [COORD_W-1:0]  voxel_y;
        logic signed [COORD_W-1:0]  voxel_z;
    } vrt_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_STEP,
        ST_OUT
    } vrt_state_t;

    typedef struct packed {
        logic       load_start;   // latch origin, cells, signs
        logic       div_start;    // start one division
        logic       div_store;    // store finished quotient
        logic       step;         // take one DDA step
        logic       emit;         // load output register
        logic [1:0] emit_kind;
        logic       clear_active;
    } vrt_cmd_t;

    typedef struct packed {
        logic div_done;
        logic div_last;           // the last of the six divisions has finished
        logic ray_active;
        logic past_reach;         // step about to exceed the reach
    } vrt_status_t;

endpackage

### design/voxel_ray_traversal.sv
// Voxel ray walker. A start transaction sets up the ray with six serial divisions in one
// shared restoring divider and then issues the starting voxel as a query. An occupancy
// answer for an active ray gives a hit, or a DDA step and then a next query or a miss; an
// answer with no active ray is dropped. One transaction is in flight at a time; the input
// stalls until the result has been taken and accepts again the cycle after. max_distance
// is written directly with cfg_we and cfg_data.
module voxel_ray_traversal
    import vrt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  vrt_in_t           in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output vrt_out_t          out_data,
    input  logic              cfg_we,
    input  logic [DIST_W-1:0] cfg_data
);
    logic [DIST_W-1:0] max_dist_reg;
    vrt_cmd_t          cmd;
    vrt_status_t       status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_dist_reg <= DIST_W'(524288);
        else if (cfg_we)
            max_dist_reg <= cfg_data;
    end

    vrt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_mode     (in_data.mode),
        .in_occupied (in_data.occupied),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .cmd         (cmd)
    );

    vrt_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (in_data),
        .max_distance (max_dist_reg),
        .cmd          (cmd),
        .status       (status),
        .out_item     (out_data)
    );
endmodule

### design/vrt_divider.sv
module vrt_divider
    import vrt_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [NUM_W-1:0]  quot
);
    // Restoring division, one quotient bit per cycle.
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        if (start)
        begin
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

### design/vrt_datapath.sv
module vrt_datapath
    import vrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  vrt_in_t             in_item,
    input  logic [DIST_W-1:0]   max_distance,
    input  vrt_cmd_t            cmd,
    output vrt_status_t         status,
    output vrt_out_t            out_item
);
    localparam int NUM_W = DIST_W + DIR_FRAC_BITS + 1;
    localparam int MAG_W = DIR_FRAC_BITS + 2;

    logic [COORD_W-1:0]        cell_reg [3];
    logic [DIST_W-1:0]         nb_reg [3];
    logic [DIST_W-1:0]         sp_reg [3];
    logic [2:0]                neg_reg;
    logic [2:0]                dzero_reg;
    logic [DIST_FRAC_BITS-1:0] frac_reg [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [DIST_W-1:0]         travelled_reg;
    logic                      active_reg;
    logic [2:0]                div_idx_reg;
    vrt_out_t                  out_reg;

    logic [COORD_W-1:0]  origin [3];
    logic [MAG_W-1:0]    dir [3];
    logic [1:0]          axis;
    logic [NUM_W-1:0]    div_num;
    logic [MAG_W-1:0]    div_den;
    logic                div_done;
    logic [NUM_W-1:0]    div_quot;
    logic [DIST_W-1:0]   div_sat;
    logic [1:0]          div_axis;
    logic                div_is_sp;
    logic [DIST_W-1:0]   nb_sel;
    logic [DIST_W:0]     nb_sum;

    assign origin[0] = in_item.origin_x;
    assign origin[1] = in_item.origin_y;
    assign origin[2] = in_item.origin_z;
    assign dir[0]    = MAG_W'(in_item.dir_x);
    assign dir[1]    = MAG_W'(in_item.dir_y);
    assign dir[2]    = MAG_W'(in_item.dir_z);

    // Divisions run boundary then spacing for x, y and z in turn.
    assign div_axis  = div_idx_reg[2:1];
    assign div_is_sp = div_idx_reg[0];

    always_comb
    begin
        div_den = mag_reg[div_axis];
        if (div_is_sp)
            div_num = NUM_W'(1) << (DIST_FRAC_BITS + DIR_FRAC_BITS);
        else if (neg_reg[div_axis])
            div_num = NUM_W'(frac_reg[div_axis]) << DIR_FRAC_BITS;
        else
            div_num = (NUM_W'(1) << (DIST_FRAC_BITS + DIR_FRAC_BITS))
                    - (NUM_W'(frac_reg[div_axis]) << DIR_FRAC_BITS);
    end

    vrt_divider #(.NUM_W(NUM_W), .DEN_W(MAG_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign div_sat = (|div_quot[NUM_W-1:DIST_W]) ? '1 : div_quot[DIST_W-1:0];

    // Nearest boundary; ties go to z, then y.
    always_comb
    begin
        if (nb_reg[0] < nb_reg[1])
            axis = (nb_reg[0] < nb_reg[2]) ? 2'd0 : 2'd2;
        else
            axis = (nb_reg[1] < nb_reg[2]) ? 2'd1 : 2'd2;
    end

    assign nb_sel = nb_reg[axis];
    assign nb_sum = {1'b0, nb_sel} + {1'b0, sp_reg[axis]};

    assign status.div_done   = div_done;
    assign status.div_last   = div_done && (div_idx_reg == 3'd5);
    assign status.ray_active = active_reg;
    assign status.past_reach = nb_sel > max_distance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            travelled_reg <= '0;
            div_idx_reg   <= '0;
            neg_reg       <= '0;
            for (int a = 0; a < 3; a++)
            begin
                cell_reg[a] <= '0;
                nb_reg[a]   <= '0;
                sp_reg[a]   <= '0;
            end
        end
        else
        begin
            if (cmd.load_start)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    cell_reg[a] <= COORD_W'($signed(origin[a]) >>> DIST_FRAC_BITS);
                    neg_reg[a]  <= dir[a][MAG_W-1] || (dir[a] == '0);
                end
                travelled_reg <= '0;
                active_reg    <= 1'b1;
                div_idx_reg   <= '0;
            end
            if (cmd.div_store)
            begin
                if (dzero_reg[div_axis])
                begin
                    if (div_is_sp)
                        sp_reg[div_axis] <= '1;
                    else
                        nb_reg[div_axis] <= '1;
                end
                else if (div_is_sp)
                    sp_reg[div_axis] <= div_sat;
                else
                    nb_reg[div_axis] <= div_sat;
                div_idx_reg <= div_idx_reg + 3'd1;
            end
            if (cmd.step)
            begin
                cell_reg[axis] <= neg_reg[axis] ? cell_reg[axis] - 1'b1
                                                : cell_reg[axis] + 1'b1;
                travelled_reg  <= nb_sel;
                nb_reg[axis]   <= nb_sum[DIST_W] ? '1 : nb_sum[DIST_W-1:0];
            end
            if (cmd.clear_active)
                active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            for (int a = 0; a < 3; a++)
            begin
                frac_reg[a]  <= origin[a][DIST_FRAC_BITS-1:0];
                mag_reg[a]   <= dir[a][MAG_W-1] ? MAG_W'(-dir[a]) : dir[a];
                dzero_reg[a] <= (dir[a] == '0);
            end
        end
        if (cmd.emit)
        begin
            out_reg.kind <= cmd.emit_kind;
            if (cmd.emit_kind == KIND_MISS)
            begin
                out_reg.voxel_x <= '0;
                out_reg.voxel_y <= '0;
                out_reg.voxel_z <= '0;
            end
            else
            begin
                out_reg.voxel_x <= cell_reg[0];
                out_reg.voxel_y <= cell_reg[1];
                out_reg.voxel_z <= cell_reg[2];
            end
        end
    end

    assign out_item = out_reg;
endmodule

### design/vrt_ctrl.sv
module vrt_ctrl
    import vrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_mode,
    input  logic        in_occupied,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  vrt_status_t status,
    output vrt_cmd_t    cmd
);
    vrt_state_t state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       accept;
    logic       miss_reg, miss_next;
    logic       hit_reg, hit_next;

    assign in_stall  = (state_reg != ST_IDLE) || ovalid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode == MODE_START)
                        state_next = ST_DIV_START;
                    else if (status.ray_active && in_occupied)
                        state_next = ST_OUT;
                    else if (status.ray_active)
                        state_next = ST_STEP;
                end
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (status.div_last)
                    state_next = ST_OUT;
                else if (status.div_done)
                    state_next = ST_DIV_START;
            end
            ST_STEP: state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        miss_next   = miss_reg;
        ovalid_next = ovalid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                miss_next = 1'b0;
                if (accept && in_mode == MODE_START)
                    cmd.load_start = 1'b1;
                else if (accept && status.ray_active && in_occupied)
                    cmd.clear_active = 1'b1;
            end
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_WAIT:  cmd.div_store = status.div_done;
            ST_STEP:
            begin
                cmd.step  = 1'b1;
                miss_next = status.past_reach;
                cmd.clear_active = status.past_reach;
            end
            ST_OUT:
            begin
                cmd.emit = 1'b1;
                // Hit clears the ray on acceptance; hit_reg, not the ray state, marks a hit.
                if (miss_reg)
                    cmd.emit_kind = KIND_MISS;
                else if (hit_reg)
                    cmd.emit_kind = KIND_HIT;
                else
                    cmd.emit_kind = KIND_QUERY;
                ovalid_next = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (state_reg == ST_IDLE)
            hit_next = accept && in_mode == MODE_ANSWER && status.ray_active && in_occupied;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            miss_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            miss_reg   <= miss_next;
            hit_reg    <= hit_next;
        end
    end
endmodule

### design/vrt_checker.sv
module vrt_checker
    import vrt_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input vrt_out_t out_data
);
    // A transaction is never taken while a result waits.
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(in_valid && !in_stall)) else $error("input taken while result pending");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.kind == KIND_QUERY || out_data.kind == KIND_HIT
                       || out_data.kind == KIND_MISS)) else $error("bad kind");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_MISS |->
            out_data.voxel_x == 0 && out_data.voxel_y == 0 && out_data.voxel_z == 0)
        else $error("miss carries a voxel");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
endmodule

bind voxel_ray_traversal vrt_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
